// ===== hdl/iirc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, register codes and control structs of the 8p8z compensator.
// No dependencies.
package iirc_pkg;

    localparam int ORDER      = 8;
    localparam int FRAC_BITS  = 24;
    localparam int DATA_W     = 32;
    localparam int NUM_COEFFS = 2 * ORDER + 1;
    localparam int CNT_W      = $clog2(NUM_COEFFS);
    localparam int IDX_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = 2 * DATA_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_LOWER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LOWER = 2'd2;

    // reset values, Q8.24
    localparam logic signed [DATA_W-1:0] UPPER_LIMIT_RST  = 32'sd16777216;   // 1.0
    localparam logic signed [DATA_W-1:0] INNER_LOWER_RST  = -32'sd15099494;  // -0.9
    localparam logic signed [DATA_W-1:0] OUTPUT_LOWER_RST = 32'sd0;

    // input function codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_COEFF  = 1'b1;

    typedef struct packed {
        logic rotate;   // pass coef/data to the lower neighbor (ring)
        logic shift;    // take history data from the lower neighbor
    } t_cell_ctrl;

    typedef struct packed {
        logic clear;       // zero product and accumulator
        logic accumulate;  // multiply head cell, add previous product
    } t_mac_ctrl;

endpackage

// ===== hdl/iirc_cell.sv =====
`timescale 1ns / 1ps
// One tap cell: a coefficient and a sample, rotated around the ring or shifted
// along the history. Depends on iirc_pkg.
module iirc_cell
    import iirc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctrl               i_ctrl,
    input  logic                     i_coef_we,
    input  logic signed [DATA_W-1:0] i_coef_wdata,
    input  logic signed [DATA_W-1:0] i_rot_coef,
    input  logic signed [DATA_W-1:0] i_rot_data,
    input  logic signed [DATA_W-1:0] i_shift_data,
    output logic signed [DATA_W-1:0] o_coef,
    output logic signed [DATA_W-1:0] o_data
);

    logic signed [DATA_W-1:0] r_coef;
    logic signed [DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
            r_data <= '0;
        end else begin
            if (i_coef_we) begin
                r_coef <= i_coef_wdata;
            end else if (i_ctrl.rotate) begin
                r_coef <= i_rot_coef;
            end
            if (i_ctrl.rotate) begin
                r_data <= i_rot_data;
            end else if (i_ctrl.shift) begin
                r_data <= i_shift_data;
            end
        end
    end

    assign o_coef = r_coef;
    assign o_data = r_data;

endmodule

// ===== hdl/iirc_mac.sv =====
`timescale 1ns / 1ps
// Q24 multiply with registered product, followed by a wrapping 32-bit accumulator.
// Depends on iirc_pkg.
module iirc_mac
    import iirc_pkg::*;
(
    input  logic                     i_clk,
    input  t_mac_ctrl                i_ctrl,
    input  logic signed [DATA_W-1:0] i_coef,
    input  logic signed [DATA_W-1:0] i_data,
    output logic signed [DATA_W-1:0] o_acc
);

    logic signed [PROD_W-1:0] w_prod_full;
    logic signed [DATA_W-1:0] r_prod;
    logic signed [DATA_W-1:0] r_acc;

    assign w_prod_full = PROD_W'(i_coef) * PROD_W'(i_data);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_prod <= '0;
            r_acc  <= '0;
        end else if (i_ctrl.accumulate) begin
            // arithmetic shift by FRAC_BITS, keep low word
            r_prod <= w_prod_full[FRAC_BITS +: DATA_W];
            r_acc  <= r_acc + r_prod;
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== hdl/iir_compensator_8p8z_q24_unit.sv =====
`timescale 1ns / 1ps
// Top level of the 8-pole 8-zero Q8.24 compensator: control sequencer, tap ring,
// MAC and output clamps. Depends on iirc_pkg, iirc_cell, iirc_mac.
//
// Each control-sample transaction (func = 0): the error is latched into the
// head cell on acceptance, the ring of tap cells rotates once past the single
// multiplier at its head (one tap per cycle), a drain step adds the last
// registered product, and a finish step clamps, updates the histories and loads
// the result, waiting while the output register holds a result not yet taken.
// The input side is ready again only after that, so no new sample is taken
// before the last is through; a finished result waits in the output register
// while the next sample is computed. A coefficient-write transaction (func = 1)
// produces no result and writes straight into the addressed cell; indexes
// above 16 are dropped. Limit registers are written through the cfg port; the
// user must write them only while idle, which the block does not enforce.
module iir_compensator_8p8z_q24_unit
    import iirc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // sample / coefficient input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_func,
    input  logic signed [DATA_W-1:0]    i_reference,
    input  logic signed [DATA_W-1:0]    i_feedback,
    input  logic        [IDX_W-1:0]     i_coeff_index,
    input  logic signed [DATA_W-1:0]    i_coeff_value,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [DATA_W-1:0]    o_control_out,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic        [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic signed [DATA_W-1:0]    i_cfg_data
);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;  // ring rotates once past the MAC
    localparam logic [1:0] S_DRAIN = 2'd2;  // last product into accumulator
    localparam logic [1:0] S_FIN   = 2'd3;  // clamp, history shift, output load

    logic [1:0]               r_state, n_state;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_data;

    logic signed [DATA_W-1:0] r_upper;
    logic signed [DATA_W-1:0] r_inner_lower;
    logic signed [DATA_W-1:0] r_output_lower;

    logic                     w_in_accept;
    logic                     w_sample_go;
    logic                     w_coef_go;
    logic                     w_fin_go;
    logic signed [DATA_W-1:0] w_err;
    logic signed [DATA_W-1:0] w_acc;
    logic signed [DATA_W-1:0] w_upper_clamped;
    logic signed [DATA_W-1:0] w_stored;
    logic signed [DATA_W-1:0] w_emitted;
    t_mac_ctrl                w_mac_ctrl;

    logic signed [DATA_W-1:0] w_coef [NUM_COEFFS];
    logic signed [DATA_W-1:0] w_data [NUM_COEFFS];

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_sample_go = w_in_accept && (i_func == FUNC_SAMPLE);
    assign w_coef_go   = w_in_accept && (i_func == FUNC_COEFF);
    assign w_fin_go    = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    assign w_err = i_reference - i_feedback;

    // ------------------------------------------------------------------
    // Tap ring. Cell 0 holds B0 and the current error, cells 1..8 hold
    // B1..B8 with e[n-1..n-8], cells 9..16 hold A1..A8 with y[n-1..n-8].
    // Rotation moves every cell down one place, cell 0 wraps to cell 16;
    // 17 rotations bring the ring home. History shift moves data up one
    // place, with cell 9 taking the newly clamped output.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NUM_COEFFS; k++) begin : g_cell
        t_cell_ctrl               w_ctrl;
        logic signed [DATA_W-1:0] w_shift_in;

        assign w_ctrl.rotate = (r_state == S_MAC);
        if (k == 0) begin : g_head
            assign w_ctrl.shift = w_sample_go;
            assign w_shift_in   = w_err;
        end else if (k == ORDER + 1) begin : g_y_head
            assign w_ctrl.shift = w_fin_go;
            assign w_shift_in   = w_stored;
        end else begin : g_body
            assign w_ctrl.shift = w_fin_go;
            assign w_shift_in   = w_data[k-1];
        end

        iirc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_coef_we    (w_coef_go && (i_coeff_index == IDX_W'(k))),
            .i_coef_wdata (i_coeff_value),
            .i_rot_coef   (w_coef[(k + 1) % NUM_COEFFS]),
            .i_rot_data   (w_data[(k + 1) % NUM_COEFFS]),
            .i_shift_data (w_shift_in),
            .o_coef       (w_coef[k]),
            .o_data       (w_data[k])
        );
    end

    // MAC at the ring head
    assign w_mac_ctrl.clear      = w_sample_go;
    assign w_mac_ctrl.accumulate = (r_state == S_MAC) || (r_state == S_DRAIN);

    iirc_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (w_mac_ctrl),
        .i_coef (w_coef[0]),
        .i_data (w_data[0]),
        .o_acc  (w_acc)
    );

    // Clamps: upper, then inner lower (wins if crossed), then output lower.
    assign w_upper_clamped = (w_acc < r_upper) ? w_acc : r_upper;
    assign w_stored        = (w_upper_clamped > r_inner_lower) ? w_upper_clamped
                                                               : r_inner_lower;
    assign w_emitted       = (w_stored > r_output_lower) ? w_stored : r_output_lower;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_sample_go) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_COEFFS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            r_out_data <= w_emitted;
        end
    end

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper        <= UPPER_LIMIT_RST;
            r_inner_lower  <= INNER_LOWER_RST;
            r_output_lower <= OUTPUT_LOWER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_UPPER_LIMIT:  r_upper        <= i_cfg_data;
                REG_INNER_LOWER:  r_inner_lower  <= i_cfg_data;
                REG_OUTPUT_LOWER: r_output_lower <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_control_out = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Ring must have rotated exactly once around before the drain cycle.
    a_full_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |->
            ($past(r_state) == S_MAC) && ($past(r_cnt) == CNT_W'(NUM_COEFFS - 1)))
        else $error("drain entered without a full ring rotation");

    // A new result only comes out of the finish step.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result raised outside finish step");

    // A coefficient write transaction never starts a computation.
    a_coef_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_coef_go |=> (r_state == S_IDLE))
        else $error("coefficient write left the idle state");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for iir_compensator_8p8z_q24_unit: directed and random sample/coefficient traffic,
// checked against a scoreboard with its own compensator predictor. Depends on iirc_pkg, the RTL.

module tb_top;
    import iirc_pkg::*;

    typedef logic signed [DATA_W-1:0] q24_t;

    // Q8.24 values used by the directed part
    localparam q24_t Q_ONE     = 32'sh0100_0000;
    localparam q24_t Q_HALF    = 32'sh0080_0000;
    localparam q24_t Q_QUARTER = 32'sh0040_0000;
    localparam q24_t Q_MAX     = 32'sh7FFF_FFFF;
    localparam q24_t Q_MIN     = 32'sh8000_0000;

    // coefficient bank addresses
    localparam logic [IDX_W-1:0] TAP_B0   = IDX_W'(0);
    localparam logic [IDX_W-1:0] TAP_B1   = IDX_W'(1);
    localparam logic [IDX_W-1:0] TAP_B8   = IDX_W'(ORDER);
    localparam logic [IDX_W-1:0] TAP_A1   = IDX_W'(ORDER + 1);
    localparam logic [IDX_W-1:0] TAP_A8   = IDX_W'(2 * ORDER);
    localparam logic [IDX_W-1:0] TAP_PAST = IDX_W'(NUM_COEFFS);  // first address off the bank
    localparam logic [IDX_W-1:0] TAP_TOP  = '1;

    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 276;
    localparam int SETTLE      = 30;   // longer than an unstalled sample computation

    // ------------------------------------------------------------------
    // Scoreboard: keeps the compensator state (taps, error and output
    // histories, limits) and a queue of predicted control outputs.
    // ------------------------------------------------------------------
    class drive_checker;
        q24_t taps[NUM_COEFFS];
        q24_t err_hist[ORDER];
        q24_t out_hist[ORDER];
        q24_t upper_lim;
        q24_t inner_lim;
        q24_t floor_lim;
        q24_t drive_q[$];
        int   errors;

        function new();
            foreach (taps[i]) taps[i] = '0;
            foreach (err_hist[i]) begin
                err_hist[i] = '0;
                out_hist[i] = '0;
            end
            upper_lim = UPPER_LIMIT_RST;
            inner_lim = INNER_LOWER_RST;
            floor_lim = OUTPUT_LOWER_RST;
            errors    = 0;
        endfunction

        function void set_limit(logic [CFG_IDX_W-1:0] idx, q24_t val);
            case (idx)
                REG_UPPER_LIMIT:  upper_lim = val;
                REG_INNER_LOWER:  inner_lim = val;
                REG_OUTPUT_LOWER: floor_lim = val;
                default: ;
            endcase
        endfunction

        // full signed product, arithmetic shift by FRAC_BITS, keep 32 bits
        function q24_t q24_product(q24_t a, q24_t b);
            logic signed [PROD_W-1:0] p;
            p = PROD_W'(a) * PROD_W'(b);
            return p[FRAC_BITS +: DATA_W];
        endfunction

        // note one accepted input transaction
        function void absorb(logic func, q24_t setpoint, q24_t meas,
                             logic [IDX_W-1:0] idx, q24_t val);
            q24_t e;
            q24_t acc;
            q24_t s;
            int   i;
            if (func == FUNC_COEFF) begin
                if (idx < NUM_COEFFS) taps[idx] = val;
                return;
            end
            e   = setpoint - meas;
            acc = q24_product(taps[0], e);
            for (i = 0; i < ORDER; i++) begin
                acc += q24_product(taps[1 + i], err_hist[i]);
                acc += q24_product(taps[1 + ORDER + i], out_hist[i]);
            end
            for (i = ORDER - 1; i > 0; i--) err_hist[i] = err_hist[i - 1];
            err_hist[0] = e;
            // upper clamp first, then inner lower; inner wins if inverted
            s = acc;
            if (!(s < upper_lim)) s = upper_lim;
            if (!(s > inner_lim)) s = inner_lim;
            for (i = ORDER - 1; i > 0; i--) out_hist[i] = out_hist[i - 1];
            out_hist[0] = s;
            if (!(s > floor_lim)) s = floor_lim;
            drive_q.push_back(s);
        endfunction

        function void check_drive(q24_t got);
            q24_t want;
            if (drive_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected control_out, expected none, actual 0x%08h",
                         $time, got);
            end else begin
                want = drive_q.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: control_out expected 0x%08h (%0d) actual 0x%08h (%0d)",
                             $time, want, want, got, got);
                end
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and its stimulus signals, all known from time zero
    // ------------------------------------------------------------------
    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_in_valid    = 1'b0;
    logic                   i_func        = FUNC_SAMPLE;
    q24_t                   i_reference   = '0;
    q24_t                   i_feedback    = '0;
    logic [IDX_W-1:0]       i_coeff_index = '0;
    q24_t                   i_coeff_value = '0;
    logic                   i_out_ready   = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = REG_UPPER_LIMIT;
    q24_t                   i_cfg_data    = '0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    q24_t                   o_control_out;

    drive_checker chk = new();

    iir_compensator_8p8z_q24_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_reference   (i_reference),
        .i_feedback    (i_feedback),
        .i_coeff_index (i_coeff_index),
        .i_coeff_value (i_coeff_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_control_out (o_control_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case a handshake hangs
    initial begin
        #1_500_000;
        $display("tb_top: errors");
        $finish;
    end

    // Output side: stretches of ready and of stall with random lengths.
    // Stalls keep a finished result parked in the output register while the
    // next sample is being computed.
    int rx_left = 0;
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                i_out_ready <= 1'b1;
                rx_left     <= $urandom_range(1, 60);
            end else begin
                i_out_ready <= 1'b0;
                rx_left     <= $urandom_range(1, 40);
            end
        end else begin
            rx_left <= rx_left - 1;
        end
    end

    // every completed output transaction goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) chk.check_drive(o_control_out);
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    int burst_left = 0;

    // Burst pacing: after a burst of random length, usually drop valid for a
    // random stretch so gaps land on every step of the sample computation.
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 25)) @(posedge i_clk);
            end
        end
    endtask

    // Present one input transaction and hold it until accepted.
    task automatic send(input logic func, input q24_t setpoint, input q24_t meas,
                        input logic [IDX_W-1:0] idx, input q24_t val);
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_reference   <= setpoint;
        i_feedback    <= meas;
        i_coeff_index <= idx;
        i_coeff_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        chk.absorb(func, setpoint, meas, idx, val);
        pace();
    endtask

    // Stop sending, wait out every expected result plus the pipeline depth
    // (a trailing coefficient write leaves no result to wait for).
    task automatic drain();
        i_in_valid <= 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write all three limit registers on back-to-back cycles; block is idle.
    task automatic set_limits(input q24_t up, input q24_t lo, input q24_t fl);
        logic [CFG_IDX_W-1:0] codes[3];
        q24_t                 vals[3];
        codes = '{REG_UPPER_LIMIT, REG_INNER_LOWER, REG_OUTPUT_LOWER};
        vals  = '{up, lo, fl};
        for (int k = 0; k < 3; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= codes[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            chk.set_limit(codes[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // uniform in [-span, span]
    function automatic q24_t rand_span(int unsigned span);
        return q24_t'($urandom_range(0, 2 * span)) - q24_t'(span);
    endfunction

    // mostly within +-2.0, sometimes anything
    function automatic q24_t rand_operand();
        return ($urandom_range(0, 9) < 7) ? rand_span(32'h0200_0000) : q24_t'($urandom);
    endfunction

    // mostly within +-0.5 so the loop stays off the clamps for a while
    function automatic q24_t rand_coeff();
        return ($urandom_range(0, 9) < 8) ? rand_span(32'h0080_0000) : q24_t'($urandom);
    endfunction

    function automatic q24_t rand_limit();
        case ($urandom_range(0, 5))
            0:       return Q_MAX;
            1:       return Q_MIN;
            5:       return q24_t'($urandom);
            default: return rand_span(32'h0400_0000);
        endcase
    endfunction

    // One random transaction; counted is low for writes the block drops.
    task automatic random_item(output bit counted);
        int               pick;
        logic [IDX_W-1:0] idx;
        pick    = $urandom_range(0, 99);
        counted = 1'b1;
        if (pick < 82) begin
            // coefficient fields are don't-care on samples, so randomize them
            send(FUNC_SAMPLE, rand_operand(), rand_operand(),
                 IDX_W'($urandom), q24_t'($urandom));
        end else begin
            if (pick < 96) idx = IDX_W'($urandom_range(0, NUM_COEFFS - 1));
            else           idx = IDX_W'($urandom);
            counted = (idx < NUM_COEFFS);
            send(FUNC_COEFF, q24_t'($urandom), q24_t'($urandom), idx, rand_coeff());
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int   sent;
        bit   counted;
        int   phase;
        int   k;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values written back explicitly
        set_limits(UPPER_LIMIT_RST, INNER_LOWER_RST, OUTPUT_LOWER_RST);

        // --- directed ---
        send(FUNC_SAMPLE, '0, '0, TAP_B0, '0);             // empty bank gives zero
        send(FUNC_COEFF, Q_MAX, Q_MIN, TAP_B0, Q_ONE);     // pure gain of 1.0
        send(FUNC_SAMPLE, Q_HALF, '0, TAP_B0, '0);
        send(FUNC_SAMPLE, Q_MAX, Q_MIN, TAP_B0, '0);       // error wraps to -1 lsb
        send(FUNC_SAMPLE, Q_MIN, Q_MAX, TAP_B0, '0);       // error wraps to +1 lsb
        send(FUNC_SAMPLE, Q_MIN, '0, TAP_B0, '0);          // hits inner clamp, floored
        send(FUNC_SAMPLE, Q_MAX, '0, TAP_B0, '0);          // hits upper clamp
        send(FUNC_COEFF, '0, '0, TAP_PAST, Q_MAX);         // off the bank: dropped
        send(FUNC_COEFF, '0, '0, TAP_TOP, Q_MIN);          // off the bank: dropped
        send(FUNC_COEFF, Q_MIN, Q_MAX, TAP_B1, -Q_HALF);
        send(FUNC_COEFF, Q_MAX, Q_MAX, TAP_B8, Q_MAX);
        send(FUNC_COEFF, Q_MIN, Q_MIN, TAP_A1, Q_QUARTER);
        send(FUNC_COEFF, '0, Q_ONE, TAP_A8, Q_MIN);
        send(FUNC_SAMPLE, Q_QUARTER, -Q_QUARTER, TAP_TOP, Q_MAX);  // coeff fields ignored
        // push the history far enough for B8 and A8 to contribute
        for (k = 0; k < 9; k++)
            send(FUNC_SAMPLE, Q_HALF, q24_t'(k * 2_000_000) - 32'sd8_000_000, TAP_B0, '0);

        // --- random phases, each with its own limit setting ---
        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0:       set_limits(Q_MAX, Q_MIN, Q_MIN);                // no clamping, wrap shows
                1:       set_limits(-Q_ONE, Q_HALF, Q_MIN);              // inverted limits
                2:       set_limits(Q_MIN, Q_MIN, Q_MAX);                // everything pinned
                3:       set_limits(UPPER_LIMIT_RST, INNER_LOWER_RST, OUTPUT_LOWER_RST);
                default: set_limits(rand_limit(), rand_limit(), rand_limit());
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                random_item(counted);
                if (counted) sent++;
            end
        end

        drain();
        if (chk.errors == 0 && chk.pending() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
